### rtl/tapdu_pkg.sv
`timescale 1ns / 1ps

package tapdu_pkg;

    localparam logic [7:0]  START_BYTE    = 8'h68;
    localparam logic [15:0] MIN_CTRL_LEN  = 16'd4;
    localparam logic [15:0] MIN_ASDU_LEN  = 16'd14;
    localparam logic [15:0] ASDU_HDR_OFFS = 16'd10;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        FMT_I   = 2'd0,
        FMT_S   = 2'd1,
        FMT_U   = 2'd2,
        FMT_BAD = 2'd3
    } t_frame_format;

    localparam logic [2:0] UCODE_NONE = 3'd0;

endpackage

### rtl/tapdu_if.sv
`timescale 1ns / 1ps

interface tapdu_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tapdu_desc_if;
    logic        valid;
    logic        ready;
    logic [1:0]  frame_format;
    logic [14:0] send_seq;
    logic [14:0] recv_seq;
    logic [2:0]  u_code;
    logic        has_asdu;
    logic [7:0]  type_id;
    logic        sequence_flag;
    logic [6:0]  object_count;
    logic [15:0] cause;
    logic [15:0] common_addr;
    logic [23:0] info_obj_addr;
    logic [15:0] info_len;

    modport source (
        output valid, output frame_format, output send_seq, output recv_seq,
        output u_code, output has_asdu, output type_id, output sequence_flag,
        output object_count, output cause, output common_addr,
        output info_obj_addr, output info_len, input ready
    );
    modport sink (
        input valid, input frame_format, input send_seq, input recv_seq,
        input u_code, input has_asdu, input type_id, input sequence_flag,
        input object_count, input cause, input common_addr,
        input info_obj_addr, input info_len, output ready
    );
endinterface

### rtl/telecontrol_apdu_frame_parser.sv
`timescale 1ns / 1ps
// channel   dir  modport  payload
// i_rx      in   sink     rx_byte, one link byte per word
// o_desc    out  source   frame descriptor, one word per frame
//
// one byte per cycle while input is ready; a descriptor appears the cycle
// after the last frame byte (or the second length byte for a short length)
// a single output register holds the descriptor; input stays ready while it
// is empty or being taken
// synchronous active-low reset returns to start-byte hunting

module telecontrol_apdu_frame_parser
    import tapdu_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    tapdu_rx_if.sink     i_rx,
    tapdu_desc_if.source o_desc
);

    t_phase      r_phase, n_phase;
    logic [15:0] r_len, n_len;
    logic [15:0] r_cnt, n_cnt;
    logic [7:0]  r_ctrl [4];
    logic [7:0]  n_ctrl [4];
    logic [7:0]  r_type, n_type;
    logic [7:0]  r_qual, n_qual;
    logic [15:0] r_cause, n_cause;
    logic [15:0] r_addr, n_addr;
    logic [23:0] r_obj, n_obj;

    logic        r_out_valid, n_out_valid;
    logic        in_fire;
    logic [7:0]  b;
    logic        last_body;
    logic        emit_short;
    logic        emit_frame;

    t_frame_format d_fmt;
    logic [14:0]   d_send, d_recv;
    logic [2:0]    d_ucode;
    logic          d_asdu;

    logic [1:0]  r_fmt;
    logic [14:0] r_send, r_recv;
    logic [2:0]  r_ucode;
    logic        r_asdu;
    logic [7:0]  r_o_type;
    logic        r_o_seq;
    logic [6:0]  r_o_cnt;
    logic [15:0] r_o_cause, r_o_addr, r_o_info_len;
    logic [23:0] r_o_obj;

    assign i_rx.ready = !r_out_valid || o_desc.ready;
    assign in_fire    = i_rx.valid && i_rx.ready;
    assign b          = i_rx.rx_byte;
    assign last_body  = (17'({1'b0, r_cnt}) + 17'd1) >= 17'({1'b0, r_len});

    // phase, length and position
    always_comb begin
        n_phase    = r_phase;
        n_len      = r_len;
        n_cnt      = r_cnt;
        emit_short = 1'b0;
        emit_frame = 1'b0;
        if (in_fire) begin
            unique case (r_phase)
                PH_HUNT: begin
                    n_cnt = '0;
                    if (b == START_BYTE) begin
                        n_phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    if (r_cnt == '0) begin
                        n_len = {8'h00, b};
                        n_cnt = 16'd1;
                    end else begin
                        n_len = {b, r_len[7:0]};
                        n_cnt = '0;
                        if ({b, r_len[7:0]} < MIN_CTRL_LEN) begin
                            emit_short = 1'b1;
                            n_phase    = PH_HUNT;
                        end else begin
                            n_phase = PH_BODY;
                        end
                    end
                end
                PH_BODY: begin
                    if (last_body) begin
                        emit_frame = 1'b1;
                        n_phase    = PH_HUNT;
                        n_cnt      = '0;
                    end else begin
                        n_cnt = r_cnt + 16'd1;
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                    n_cnt   = '0;
                end
            endcase
        end
    end

    // body capture
    always_comb begin
        n_ctrl  = r_ctrl;
        n_type  = r_type;
        n_qual  = r_qual;
        n_cause = r_cause;
        n_addr  = r_addr;
        n_obj   = r_obj;
        if (in_fire && r_phase == PH_BODY) begin
            case (r_cnt)
                16'd0:   n_ctrl[0] = b;
                16'd1:   n_ctrl[1] = b;
                16'd2:   n_ctrl[2] = b;
                16'd3:   n_ctrl[3] = b;
                16'd4:   n_type = b;
                16'd5:   n_qual = b;
                16'd6:   n_cause[7:0] = b;
                16'd7:   n_cause[15:8] = b;
                16'd8:   n_addr[7:0] = b;
                16'd9:   n_addr[15:8] = b;
                16'd10:  n_obj[7:0] = b;
                16'd11:  n_obj[15:8] = b;
                16'd12:  n_obj[23:16] = b;
                default: ;
            endcase
        end
    end

    // control field decode on the completed frame
    always_comb begin
        d_fmt   = FMT_BAD;
        d_send  = '0;
        d_recv  = '0;
        d_ucode = UCODE_NONE;
        if (!n_ctrl[0][0] && !n_ctrl[2][0]) begin
            d_fmt = FMT_I;
        end else if (n_ctrl[0][1:0] == 2'b01) begin
            d_fmt = FMT_S;
        end else if (n_ctrl[0][1:0] == 2'b11) begin
            d_fmt = FMT_U;
        end
        if (d_fmt == FMT_U) begin
            for (int i = 7; i >= 2; i--) begin
                if (n_ctrl[0][i]) begin
                    d_ucode = 3'(i - 1);
                end
            end
        end else if (d_fmt != FMT_BAD) begin
            d_send = {n_ctrl[1], n_ctrl[0][7:1]};
            d_recv = {n_ctrl[3], n_ctrl[2][7:1]};
        end
        d_asdu = (d_fmt != FMT_BAD) && (r_len >= MIN_ASDU_LEN);
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (in_fire && (emit_short || emit_frame)) begin
            n_out_valid = 1'b1;
        end else if (o_desc.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_len       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_len       <= n_len;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ctrl  <= n_ctrl;
        r_type  <= n_type;
        r_qual  <= n_qual;
        r_cause <= n_cause;
        r_addr  <= n_addr;
        r_obj   <= n_obj;
    end

    always_ff @(posedge i_clk) begin
        if (emit_short) begin
            r_fmt        <= FMT_BAD;
            r_send       <= '0;
            r_recv       <= '0;
            r_ucode      <= UCODE_NONE;
            r_asdu       <= 1'b0;
            r_o_type     <= '0;
            r_o_seq      <= 1'b0;
            r_o_cnt      <= '0;
            r_o_cause    <= '0;
            r_o_addr     <= '0;
            r_o_obj      <= '0;
            r_o_info_len <= '0;
        end else if (emit_frame) begin
            r_fmt        <= d_fmt;
            r_send       <= d_send;
            r_recv       <= d_recv;
            r_ucode      <= d_ucode;
            r_asdu       <= d_asdu;
            r_o_type     <= d_asdu ? n_type : 8'h00;
            r_o_seq      <= d_asdu ? n_qual[7] : 1'b0;
            r_o_cnt      <= d_asdu ? n_qual[6:0] : 7'h00;
            r_o_cause    <= d_asdu ? n_cause : 16'h0000;
            r_o_addr     <= d_asdu ? n_addr : 16'h0000;
            r_o_obj      <= d_asdu ? n_obj : 24'h000000;
            r_o_info_len <= d_asdu ? (r_len - ASDU_HDR_OFFS) : 16'h0000;
        end
    end

    assign o_desc.valid         = r_out_valid;
    assign o_desc.frame_format  = r_fmt;
    assign o_desc.send_seq      = r_send;
    assign o_desc.recv_seq      = r_recv;
    assign o_desc.u_code        = r_ucode;
    assign o_desc.has_asdu      = r_asdu;
    assign o_desc.type_id       = r_o_type;
    assign o_desc.sequence_flag = r_o_seq;
    assign o_desc.object_count  = r_o_cnt;
    assign o_desc.cause         = r_o_cause;
    assign o_desc.common_addr   = r_o_addr;
    assign o_desc.info_obj_addr = r_o_obj;
    assign o_desc.info_len      = r_o_info_len;

endmodule

### rtl/tapdu_chk.sv
`timescale 1ns / 1ps

module tapdu_chk
    import tapdu_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [1:0]  i_fmt,
    input logic [14:0] i_send,
    input logic [14:0] i_recv,
    input logic [2:0]  i_ucode,
    input logic        i_asdu,
    input logic [7:0]  i_type,
    input logic        i_seq,
    input logic [6:0]  i_cnt,
    input logic [15:0] i_cause,
    input logic [15:0] i_addr,
    input logic [23:0] i_obj,
    input logic [15:0] i_info_len
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("descriptor dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> $stable(i_fmt) && $stable(i_send) && $stable(i_recv)
            && $stable(i_info_len))
        else $error("descriptor changed while stalled");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_fmt == FMT_BAD |-> i_send == '0 && i_recv == '0
            && i_ucode == UCODE_NONE && !i_asdu)
        else $error("bad frame carries fields");

    a_u_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_fmt == FMT_U) ? (i_send == '0 && i_recv == '0)
            : (i_ucode == UCODE_NONE))
        else $error("sequence counts and u function mixed");

    a_asdu_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_asdu |-> i_type == '0 && !i_seq && i_cnt == '0
            && i_cause == '0 && i_addr == '0 && i_obj == '0 && i_info_len == '0)
        else $error("asdu fields set without asdu");

endmodule

bind telecontrol_apdu_frame_parser tapdu_chk u_tapdu_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (o_desc.valid),
    .i_ready    (o_desc.ready),
    .i_fmt      (o_desc.frame_format),
    .i_send     (o_desc.send_seq),
    .i_recv     (o_desc.recv_seq),
    .i_ucode    (o_desc.u_code),
    .i_asdu     (o_desc.has_asdu),
    .i_type     (o_desc.type_id),
    .i_seq      (o_desc.sequence_flag),
    .i_cnt      (o_desc.object_count),
    .i_cause    (o_desc.cause),
    .i_addr     (o_desc.common_addr),
    .i_obj      (o_desc.info_obj_addr),
    .i_info_len (o_desc.info_len)
);
